// ----- rtl/core/grouped_cell_statistics_macros.svh -----
// Assertion macros shared by the checkers of grouped_cell_statistics.
// No dependencies; taken in by `include where assertions are written.
`ifndef GROUPED_CELL_STATISTICS_MACROS_SVH
`define GROUPED_CELL_STATISTICS_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define GCS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define GCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/gcs_pkg.sv -----
// Shared types and constants of the grouped cell statistics block.
// No dependencies; used by every module of the block.
package gcs_pkg;

   localparam int IDX_W   = 6;
   localparam int VAL_W   = 32;
   localparam int COUNT_W = 20;
   localparam int SUM_W   = 48;

   localparam int ROWS_DEFAULT = 64;
   localparam int COLS_DEFAULT = 64;

   localparam logic ACTION_ACCUM = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [VAL_W-1:0]   VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0]   VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic        [COUNT_W-1:0] count;
      logic signed [SUM_W-1:0]   total;
      logic signed [VAL_W-1:0]   smallest;
      logic signed [VAL_W-1:0]   largest;
   } cell_stats_type;

   localparam cell_stats_type CELL_EMPTY = '{
      count:    '0,
      total:    '0,
      smallest: VAL_MAX,
      largest:  VAL_MIN
   };

endpackage

// ----- rtl/core/gcs_store.sv -----
// Cell statistics memory with one read and one write port and registered read data.
// Runs a clearing sweep after reset. Depends on gcs_pkg.
module gcs_store #(
   parameter int CELLS  = gcs_pkg::ROWS_DEFAULT * gcs_pkg::COLS_DEFAULT,
   parameter int ADDR_W = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output gcs_pkg::cell_stats_type rd_data,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  gcs_pkg::cell_stats_type wr_data,
   output logic                    clearing
);
   import gcs_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   cell_stats_type store_ff [CELLS];
   cell_stats_type rd_data_ff;
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_ptr_ff, clear_ptr_in;

   always_comb begin
      clearing_in  = clearing_ff;
      clear_ptr_in = clear_ptr_ff;
      if (clearing_ff) begin
         clear_ptr_in = clear_ptr_ff + 1'b1;
         if (clear_ptr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_ptr_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_ptr_ff <= clear_ptr_in;
      end
   end

   // Read-first: a read at the address being written returns the old entry.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         store_ff[clear_ptr_ff] <= CELL_EMPTY;
      end else if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

// ----- rtl/core/gcs_update.sv -----
// Update of one cell's statistics by one sample: saturating count and sum, min and max.
// Depends on gcs_pkg.
module gcs_update (
   input  gcs_pkg::cell_stats_type       cur,
   input  logic signed [gcs_pkg::VAL_W-1:0] value,
   output gcs_pkg::cell_stats_type       nxt
);
   import gcs_pkg::*;

   logic [SUM_W:0] sum_wide;

   assign sum_wide = {cur.total[SUM_W-1], cur.total}
                   + {{(SUM_W+1-VAL_W){value[VAL_W-1]}}, value};

   always_comb begin
      nxt = cur;
      if (cur.count != COUNT_MAX) begin
         nxt.count = cur.count + 1'b1;
      end
      // The two top bits differ only when the sum left the 48-bit range.
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         nxt.total = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         nxt.total = sum_wide[SUM_W-1:0];
      end
      if (value < cur.smallest) begin
         nxt.smallest = value;
      end
      if (value > cur.largest) begin
         nxt.largest = value;
      end
   end

endmodule

// ----- rtl/core/grouped_cell_statistics.sv -----
// Grouped cell statistics: per-cell count, sum, minimum and maximum in one memory.
// A read beat's result passes through stage 1 and the result register before it is on the rsp_ ports.
// Throughput: one beat per cycle while busy is low; the read-modify-write path forwards back-to-back updates.
// Reset: synchronous; afterwards busy stays high while the memory clears every cell.
// The result channel cannot stall; each result is shown for one cycle under rsp_strobe.
// Depends on gcs_pkg, gcs_store and gcs_update.
module grouped_cell_statistics #(
   parameter int ROWS = gcs_pkg::ROWS_DEFAULT,
   parameter int COLS = gcs_pkg::COLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [gcs_pkg::IDX_W-1:0]           req_row_index,
   input  logic [gcs_pkg::IDX_W-1:0]           req_col_index,
   input  logic signed [gcs_pkg::VAL_W-1:0]    req_value,
   output logic                                rsp_strobe,
   output logic [gcs_pkg::COUNT_W-1:0]         rsp_count,
   output logic signed [gcs_pkg::SUM_W-1:0]    rsp_total,
   output logic signed [gcs_pkg::VAL_W-1:0]    rsp_smallest,
   output logic signed [gcs_pkg::VAL_W-1:0]    rsp_largest
);
   import gcs_pkg::*;

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   // Stage 0 decodes the beat and issues the memory read.
   logic              accept;
   logic              in_table;
   logic [31:0]       cell_index;
   logic [ADDR_W-1:0] rd_addr;
   logic              clearing;

   assign accept     = start && !clearing;
   assign in_table   = (32'(req_row_index) < ROWS) && (32'(req_col_index) < COLS);
   assign cell_index = 32'(req_row_index) * 32'(COLS) + 32'(req_col_index);
   assign rd_addr    = cell_index[ADDR_W-1:0];

   // Stage 1 holds the beat while the memory returns the cell.
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_action_ff;
   logic                    s1_inside_ff;
   logic [ADDR_W-1:0]       s1_addr_ff;
   logic signed [VAL_W-1:0] s1_value_ff;

   // The last update written, forwarded when the next beat hits the same cell.
   // The memory is read-first, so that beat's read data is one write behind.
   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff;
   cell_stats_type    fwd_data_ff;

   cell_stats_type rd_data;
   cell_stats_type cur;
   cell_stats_type upd;
   logic           wr_en;

   logic           rsp_strobe_ff, rsp_strobe_in;
   cell_stats_type rsp_data_ff, rsp_data_in;

   gcs_store #(
      .CELLS  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept && in_table),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (s1_addr_ff),
      .wr_data  (upd),
      .clearing (clearing)
   );

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur = fwd_data_ff;
      end else begin
         cur = rd_data;
      end
   end

   gcs_update u_update (
      .cur   (cur),
      .value (s1_value_ff),
      .nxt   (upd)
   );

   // Accumulates outside the table are dropped; reads there return an empty cell.
   assign wr_en        = s1_valid_ff && s1_inside_ff && (s1_action_ff == ACTION_ACCUM);
   assign s1_valid_in  = accept;
   assign fwd_valid_in = wr_en;

   always_comb begin
      rsp_strobe_in = s1_valid_ff && (s1_action_ff == ACTION_READ);
      rsp_data_in   = s1_inside_ff ? cur : CELL_EMPTY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_inside_ff <= in_table;
         s1_addr_ff   <= rd_addr;
         s1_value_ff  <= req_value;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= upd;
      end
      if (rsp_strobe_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign busy         = clearing;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_count    = rsp_data_ff.count;
   assign rsp_total    = rsp_data_ff.total;
   assign rsp_smallest = rsp_data_ff.smallest;
   assign rsp_largest  = rsp_data_ff.largest;

endmodule

// ----- rtl/core/gcs_checker.sv -----
// Port-level checker for grouped_cell_statistics and its bind to the top level.
// Depends on grouped_cell_statistics_macros.svh and gcs_pkg.
`include "grouped_cell_statistics_macros.svh"

module gcs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_action,
   input logic rsp_strobe
);
   import gcs_pkg::*;

   logic read_taken;

   assign read_taken = start && !busy && (req_action == ACTION_READ);

   `GCS_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, busy)
   `GCS_ASSERT_IMPLIES(a_no_result_while_clearing, clock, reset, busy, !rsp_strobe)
   `GCS_ASSERT_NEXT(a_read_gives_result, clock, reset, read_taken, ##1 rsp_strobe)
   `GCS_ASSERT_IMPLIES(a_result_from_read, clock, reset, rsp_strobe, $past(read_taken, 2))

endmodule

bind grouped_cell_statistics gcs_checker u_gcs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_action (req_action),
   .rsp_strobe (rsp_strobe)
);
